### hw/rtl/threshold_alarm_qualifier_top_defines.svh
// Assertion macros for the threshold alarm qualifier checker.
// No dependencies; included by the checker file only.
`ifndef THRESHOLD_ALARM_QUALIFIER_TOP_DEFINES_SVH
`define THRESHOLD_ALARM_QUALIFIER_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define TAQ_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("taq assertion failed");

// next-cycle implication, disabled during reset
`define TAQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("taq assertion failed");

// next-cycle implication that is checked through reset as well
`define TAQ_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("taq assertion failed");

`endif

### hw/rtl/taq_pkg.sv
// Shared constants, codes and types of the threshold alarm qualifier.
// No dependencies; imported by every module of the block.
package taq_pkg;

    localparam int CHANNELS = 64;
    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CH_W     = 6;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = 8;
    localparam int LIMIT_W  = 4;

    localparam logic [CNT_W-1:0]   CNT_MAX      = '1;
    localparam logic [LIMIT_W-1:0] PERSIST_BASE = 4'd3;
    localparam logic [LIMIT_W-1:0] PERSIST_LONG = 4'd9;
    localparam logic [LIMIT_W-1:0] PERSIST_VOLT = 4'd2;

    // floor(13*r/10) = r + 19659*r[31:16] + floor((18*r[31:16] + 3*r[15:0]) / 10)
    localparam int HI_PROD_W = 31;
    localparam int LO_SUM_W  = 21;
    localparam int QUOT_W    = 18;
    localparam int CAP_W     = 33;
    localparam logic [14:0] HI_RECIP     = 15'd19659;
    localparam int          DIV10_SHIFT  = 25;
    localparam logic [21:0] DIV10_RECIP  = 22'd3355444;
    localparam int          DIV10_PROD_W = LO_SUM_W + 22;

    typedef enum logic [2:0] {
        CODE_OK        = 3'd0,
        CODE_MIN       = 3'd1,
        CODE_WARN_LOW  = 3'd2,
        CODE_WARN_HIGH = 3'd3,
        CODE_MAX       = 3'd4
    } t_alarm_code;

    typedef struct packed {
        logic [DATA_W-1:0] max_lim;
        logic [DATA_W-1:0] crit_max;
        logic [DATA_W-1:0] crit_min;
        logic [DATA_W-1:0] min_lim;
    } t_limits;

    typedef struct packed {
        logic enable;
        logic is_voltage;
        logic long_uptime;
        logic commit_permit;
    } t_flags;

    typedef struct packed {
        t_alarm_code      cls;
        logic [CNT_W-1:0] cnt;
    } t_chan_state;

    localparam t_chan_state STATE_RESET = '{cls: CODE_OK, cnt: '0};

    typedef struct packed {
        logic                rd_en;
        logic [CH_IDX_W-1:0] idx;
    } t_state_rd;

    typedef struct packed {
        logic                en;
        logic [CH_IDX_W-1:0] idx;
        t_chan_state         data;
    } t_state_wr;

endpackage

### hw/rtl/taq_classify.sv
// Threshold ordering and reading classification (combinational).
// Depends on taq_pkg.
module taq_classify import taq_pkg::*; (
    input  logic [DATA_W-1:0] i_value,
    input  t_limits           i_lim,     // max already capped by rated value
    output t_limits           o_lim,
    output t_alarm_code       o_cls
);

    logic c_lt_m, n_lt_m, n_lt_c, l_lt_m, l_lt_c, l_lt_n;
    logic v_gt_m, v_gt_c, v_lt_m, v_lt_c, v_lt_n, v_lt_l;

    // all compares run against the uncorrected values in parallel;
    // x is below a min of several values only if it is below each of them
    always_comb begin
        c_lt_m = i_lim.crit_max < i_lim.max_lim;
        n_lt_m = i_lim.crit_min < i_lim.max_lim;
        n_lt_c = i_lim.crit_min < i_lim.crit_max;
        l_lt_m = i_lim.min_lim  < i_lim.max_lim;
        l_lt_c = i_lim.min_lim  < i_lim.crit_max;
        l_lt_n = i_lim.min_lim  < i_lim.crit_min;
        v_gt_m = i_value > i_lim.max_lim;
        v_gt_c = i_value > i_lim.crit_max;
        v_lt_m = i_value < i_lim.max_lim;
        v_lt_c = i_value < i_lim.crit_max;
        v_lt_n = i_value < i_lim.crit_min;
        v_lt_l = i_value < i_lim.min_lim;

        o_lim.max_lim  = i_lim.max_lim;
        o_lim.crit_max = c_lt_m ? i_lim.crit_max : i_lim.max_lim;
        o_lim.crit_min = (n_lt_m && n_lt_c) ? i_lim.crit_min : o_lim.crit_max;
        o_lim.min_lim  = (l_lt_m && l_lt_c && l_lt_n) ? i_lim.min_lim : o_lim.crit_min;

        if (v_gt_m) begin
            o_cls = CODE_MAX;
        end else if (v_gt_c) begin
            o_cls = CODE_WARN_HIGH;
        end else begin
            o_cls = CODE_OK;
        end
        // low side overrides high side
        if (v_lt_l && v_lt_n && v_lt_m && v_lt_c) begin
            o_cls = CODE_MIN;
        end else if (v_lt_n && v_lt_m && v_lt_c) begin
            o_cls = CODE_WARN_LOW;
        end
    end

endmodule

### hw/rtl/taq_state.sv
// Per-channel alarm class and mismatch count store with write forwarding.
// Depends on taq_pkg.
module taq_state import taq_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_state_rd   i_rd,
    input  t_state_wr   i_wr,
    output t_chan_state o_state
);

    t_chan_state         r_mem [CHANNELS];
    logic [CHANNELS-1:0] r_vld;
    t_chan_state         r_rd_data;
    logic                r_rd_vld;
    logic                r_fwd;
    t_chan_state         r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.data;
        end
        if (i_rd.rd_en) begin
            r_rd_data  <= r_mem[i_rd.idx];
            r_fwd_data <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_fwd    <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.idx] <= 1'b1;
            end
            if (i_rd.rd_en) begin
                r_rd_vld <= r_vld[i_rd.idx];
                // a write landing on the same edge wins over the stale array
                r_fwd    <= i_wr.en && (i_wr.idx == i_rd.idx);
            end
        end
    end

    assign o_state = r_fwd ? r_fwd_data : (r_rd_vld ? r_rd_data : STATE_RESET);

endmodule

### hw/rtl/threshold_alarm_qualifier_top.sv
// Threshold alarm qualifier: caps and orders four thresholds, classifies the reading
// and debounces the alarm class per channel. Depends on taq_pkg, taq_classify, taq_state.
// Throughput one item per cycle while the result channel does not stall.
// Each stage advances on its own, so bubbles collapse and items enter while a result waits.
// Reset (i_rst_n low, synchronous): pipeline empties, every channel reads as class ok, count 0.
module threshold_alarm_qualifier_top import taq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [CH_W-1:0]   i_channel,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_max_limit,
    input  logic [DATA_W-1:0] i_crit_max_limit,
    input  logic [DATA_W-1:0] i_crit_min_limit,
    input  logic [DATA_W-1:0] i_min_limit,
    input  logic [DATA_W-1:0] i_rated_value,
    input  logic              i_enable,
    input  logic              i_is_voltage,
    input  logic              i_long_uptime,
    input  logic              i_commit_permit,
    // result channel
    output logic              o_valid,
    input  logic              i_stall,
    output logic [2:0]        o_alarm_code,
    output logic              o_changed,
    output logic              o_severe,
    output logic              o_warning,
    output logic [DATA_W-1:0] o_new_max,
    output logic [DATA_W-1:0] o_new_crit_max,
    output logic [DATA_W-1:0] o_new_crit_min,
    output logic [DATA_W-1:0] o_new_min
);

    // Stages:
    //   s1  input register; rated value split into high and low halves
    //   s2  reciprocal multiply for the divide by ten, partial cap sum
    //   s3  final cap add, cap compare on max
    //   s4  threshold ordering and class; state read issued on exit
    //   s5  read-modify-write of the channel state
    //   out result register

    // ---------------- handshake ----------------
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_o_valid;
    logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

    assign rdy6 = !r_o_valid || !i_stall;
    assign rdy5 = !r_s5_v || rdy6;
    assign rdy4 = !r_s4_v || rdy5;
    assign rdy3 = !r_s3_v || rdy4;
    assign rdy2 = !r_s2_v || rdy3;
    assign rdy1 = !r_s1_v || rdy2;
    assign o_stall = !rdy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v    <= 1'b0;
            r_s2_v    <= 1'b0;
            r_s3_v    <= 1'b0;
            r_s4_v    <= 1'b0;
            r_s5_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (rdy1) r_s1_v    <= i_valid;
            if (rdy2) r_s2_v    <= r_s1_v;
            if (rdy3) r_s3_v    <= r_s2_v;
            if (rdy4) r_s4_v    <= r_s3_v;
            if (rdy5) r_s5_v    <= r_s4_v;
            if (rdy6) r_o_valid <= r_s5_v;
        end
    end

    // ---------------- s1: input register ----------------
    logic [CH_W-1:0]   r_s1_ch;
    logic [DATA_W-1:0] r_s1_value;
    t_limits           r_s1_lim;
    logic [DATA_W-1:0] r_s1_rated;
    t_flags            r_s1_flags;

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_s1_ch    <= i_channel;
            r_s1_value <= i_value;
            r_s1_lim   <= '{max_lim: i_max_limit, crit_max: i_crit_max_limit,
                            crit_min: i_crit_min_limit, min_lim: i_min_limit};
            r_s1_rated <= i_rated_value;
            r_s1_flags <= '{enable: i_enable, is_voltage: i_is_voltage,
                            long_uptime: i_long_uptime, commit_permit: i_commit_permit};
        end
    end

    // 13r/10 = r + 3r/10; 3r/10 split at bit 16 since 65536 = 6553*10 + 6
    logic [HI_PROD_W-1:0] n_s2_hi;
    logic [LO_SUM_W-1:0]  n_s2_lo;
    logic [LO_SUM_W-1:0]  s1_rh, s1_rl;

    assign s1_rh   = LO_SUM_W'(r_s1_rated[DATA_W-1:16]);
    assign s1_rl   = LO_SUM_W'(r_s1_rated[15:0]);
    assign n_s2_hi = HI_PROD_W'(r_s1_rated[DATA_W-1:16]) * HI_PROD_W'(HI_RECIP);
    assign n_s2_lo = (s1_rh << 4) + (s1_rh << 1) + (s1_rl << 1) + s1_rl;

    // ---------------- s2 ----------------
    logic [CH_W-1:0]      r_s2_ch;
    logic [DATA_W-1:0]    r_s2_value;
    t_limits              r_s2_lim;
    logic [DATA_W-1:0]    r_s2_rated;
    t_flags               r_s2_flags;
    logic [HI_PROD_W-1:0] r_s2_hi;
    logic [LO_SUM_W-1:0]  r_s2_lo;

    always_ff @(posedge i_clk) begin
        if (rdy2 && r_s1_v) begin
            r_s2_ch    <= r_s1_ch;
            r_s2_value <= r_s1_value;
            r_s2_lim   <= r_s1_lim;
            r_s2_rated <= r_s1_rated;
            r_s2_flags <= r_s1_flags;
            r_s2_hi    <= n_s2_hi;
            r_s2_lo    <= n_s2_lo;
        end
    end

    // divide by ten via reciprocal: exact for the low-sum range
    logic [DIV10_PROD_W-1:0] s2_div_prod;
    logic [QUOT_W-1:0]       n_s3_quot;
    logic [CAP_W-1:0]        n_s3_sum;

    assign s2_div_prod = DIV10_PROD_W'(r_s2_lo) * DIV10_PROD_W'(DIV10_RECIP);
    assign n_s3_quot   = s2_div_prod[DIV10_SHIFT +: QUOT_W];
    assign n_s3_sum    = CAP_W'(r_s2_rated) + CAP_W'(r_s2_hi);

    // ---------------- s3 ----------------
    logic [CH_W-1:0]   r_s3_ch;
    logic [DATA_W-1:0] r_s3_value;
    t_limits           r_s3_lim;
    logic              r_s3_rnz;
    t_flags            r_s3_flags;
    logic [QUOT_W-1:0] r_s3_quot;
    logic [CAP_W-1:0]  r_s3_sum;

    always_ff @(posedge i_clk) begin
        if (rdy3 && r_s2_v) begin
            r_s3_ch    <= r_s2_ch;
            r_s3_value <= r_s2_value;
            r_s3_lim   <= r_s2_lim;
            r_s3_rnz   <= |r_s2_rated;
            r_s3_flags <= r_s2_flags;
            r_s3_quot  <= n_s3_quot;
            r_s3_sum   <= n_s3_sum;
        end
    end

    logic [CAP_W-1:0] s3_cap;
    logic             s3_do_cap;
    t_limits          n_s4_lim;

    // a disabled channel passes its thresholds through untouched
    assign s3_cap    = r_s3_sum + CAP_W'(r_s3_quot);
    assign s3_do_cap = r_s3_rnz && r_s3_flags.enable
                       && (CAP_W'(r_s3_lim.max_lim) > s3_cap);

    always_comb begin
        n_s4_lim = r_s3_lim;
        if (s3_do_cap) begin
            n_s4_lim.max_lim = s3_cap[DATA_W-1:0];
        end
    end

    // ---------------- s4 ----------------
    logic [CH_W-1:0]   r_s4_ch;
    logic [DATA_W-1:0] r_s4_value;
    t_limits           r_s4_lim;
    t_flags            r_s4_flags;

    always_ff @(posedge i_clk) begin
        if (rdy4 && r_s3_v) begin
            r_s4_ch    <= r_s3_ch;
            r_s4_value <= r_s3_value;
            r_s4_lim   <= n_s4_lim;
            r_s4_flags <= r_s3_flags;
        end
    end

    t_limits     s4_lim_corr;
    t_alarm_code s4_cls;
    t_limits     n_s5_lim;
    logic        n_s5_valid_ch;

    taq_classify u_classify (
        .i_value (r_s4_value),
        .i_lim   (r_s4_lim),
        .o_lim   (s4_lim_corr),
        .o_cls   (s4_cls)
    );

    assign n_s5_lim      = r_s4_flags.enable ? s4_lim_corr : r_s4_lim;
    assign n_s5_valid_ch = 32'(r_s4_ch) < 32'(CHANNELS);

    // ---------------- s5: channel state update ----------------
    logic [CH_IDX_W-1:0] r_s5_idx;
    logic                r_s5_valid_ch;
    t_alarm_code         r_s5_cls;
    t_limits             r_s5_lim;
    t_flags              r_s5_flags;

    always_ff @(posedge i_clk) begin
        if (rdy5 && r_s4_v) begin
            r_s5_idx      <= CH_IDX_W'(r_s4_ch);
            r_s5_valid_ch <= n_s5_valid_ch;
            r_s5_cls      <= s4_cls;
            r_s5_lim      <= n_s5_lim;
            r_s5_flags    <= r_s4_flags;
        end
    end

    t_state_rd   st_rd;
    t_state_wr   st_wr;
    t_chan_state st_rdata;

    assign st_rd.rd_en = rdy5 && r_s4_v;
    assign st_rd.idx   = CH_IDX_W'(r_s4_ch);

    taq_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (st_rd),
        .i_wr    (st_wr),
        .o_state (st_rdata)
    );

    t_chan_state          s5_prev;
    t_chan_state          s5_next;
    logic [LIMIT_W-1:0]   s5_limit;
    t_alarm_code          n_o_code;
    logic                 n_o_changed;

    // channels beyond the store act as ok with zero count, never updated
    assign s5_prev  = r_s5_valid_ch ? st_rdata : STATE_RESET;
    assign s5_limit = (r_s5_flags.long_uptime ? PERSIST_LONG : PERSIST_BASE)
                      + (r_s5_flags.is_voltage ? PERSIST_VOLT : '0);

    always_comb begin
        s5_next     = s5_prev;
        n_o_code    = CODE_OK;
        n_o_changed = 1'b0;
        if (!r_s5_flags.enable) begin
            s5_next.cls = CODE_OK;
        end else if (s5_prev.cls != r_s5_cls) begin
            // mismatch: count up (saturating) whatever the permit
            if (s5_prev.cnt != CNT_MAX) begin
                s5_next.cnt = s5_prev.cnt + CNT_W'(1);
            end
            // commit uses the count from before this item
            if ((s5_prev.cnt > CNT_W'(s5_limit)) && r_s5_flags.commit_permit
                && r_s5_valid_ch) begin
                s5_next.cls = r_s5_cls;
                n_o_code    = r_s5_cls;
                n_o_changed = 1'b1;
            end
        end else begin
            s5_next.cnt = '0;
            n_o_code    = r_s5_cls;
        end
    end

    assign st_wr.en   = r_s5_v && rdy6 && r_s5_valid_ch;
    assign st_wr.idx  = r_s5_idx;
    assign st_wr.data = s5_next;

    // ---------------- result register ----------------
    t_alarm_code r_o_code;
    logic        r_o_changed;
    logic        r_o_severe;
    logic        r_o_warning;
    t_limits     r_o_lim;

    always_ff @(posedge i_clk) begin
        if (rdy6 && r_s5_v) begin
            r_o_code    <= n_o_code;
            r_o_changed <= n_o_changed;
            r_o_severe  <= (n_o_code == CODE_MAX) || (n_o_code == CODE_MIN);
            r_o_warning <= (n_o_code == CODE_WARN_HIGH) || (n_o_code == CODE_WARN_LOW);
            r_o_lim     <= r_s5_lim;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_alarm_code   = r_o_code;
    assign o_changed      = r_o_changed;
    assign o_severe       = r_o_severe;
    assign o_warning      = r_o_warning;
    assign o_new_max      = r_o_lim.max_lim;
    assign o_new_crit_max = r_o_lim.crit_max;
    assign o_new_crit_min = r_o_lim.crit_min;
    assign o_new_min      = r_o_lim.min_lim;

endmodule

### hw/rtl/taq_checker.sv
// Port-level checker for the threshold alarm qualifier, bound to the top level.
// Depends on taq_pkg and threshold_alarm_qualifier_top_defines.svh.
`include "threshold_alarm_qualifier_top_defines.svh"

module taq_checker import taq_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_valid,
    input logic              i_stall,
    input logic [2:0]        o_alarm_code,
    input logic              o_changed,
    input logic              o_severe,
    input logic              o_warning,
    input logic [DATA_W-1:0] o_new_max,
    input logic [DATA_W-1:0] o_new_crit_max,
    input logic [DATA_W-1:0] o_new_crit_min,
    input logic [DATA_W-1:0] o_new_min
);

    // severity flags follow the reported code
    `TAQ_ASSERT_NOW(a_sev_flags, i_clk, i_rst_n, o_valid, (o_severe == ((o_alarm_code == CODE_MAX) || (o_alarm_code == CODE_MIN))) && (o_warning == ((o_alarm_code == CODE_WARN_HIGH) || (o_alarm_code == CODE_WARN_LOW))))

    // any non-ok or committed result came from an enabled channel, so thresholds are ordered
    `TAQ_ASSERT_NOW(a_order, i_clk, i_rst_n, o_valid && ((o_alarm_code != CODE_OK) || o_changed), (o_new_min <= o_new_crit_min) && (o_new_crit_min <= o_new_crit_max) && (o_new_crit_max <= o_new_max))

    // a stalled result holds
    `TAQ_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_alarm_code) && $stable(o_changed) && $stable(o_new_max) && $stable(o_new_min))

    // reset empties the result register
    `TAQ_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n, !o_valid)

endmodule

bind threshold_alarm_qualifier_top taq_checker u_taq_checker (.*);

### sim/taq_alarm_checker.sv
// Checker for the threshold alarm qualifier: watches both channels, predicts each result
// from the accepted item and compares it field by field. Depends on taq_pkg.
module taq_alarm_checker import taq_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input channel as seen at the block
    input  logic              i_in_valid,
    input  logic              i_in_stall,
    input  logic [CH_W-1:0]   i_channel,
    input  logic [DATA_W-1:0] i_value,
    input  t_limits           i_limits,
    input  logic [DATA_W-1:0] i_rated_value,
    input  t_flags            i_flags,
    // result channel as seen at the block
    input  logic              i_res_valid,
    input  logic              i_res_stall,
    input  logic [2:0]        i_alarm_code,
    input  logic              i_changed,
    input  logic              i_severe,
    input  logic              i_warning,
    input  t_limits           i_new_limits,
    // status for the testbench top
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        t_alarm_code code;
        logic        changed;
        logic        severe;
        logic        warning;
        t_limits     lim;
    } t_alarm_result;

    t_chan_state   chan_state [CHANNELS];
    t_alarm_result alarm_q [$];

    // one read-modify-write of the channel's class and mismatch count
    function automatic t_alarm_result qualify_reading(
        logic [CH_W-1:0]   ch,
        logic [DATA_W-1:0] value,
        t_limits           lim,
        logic [DATA_W-1:0] rated,
        t_flags            fl
    );
        t_alarm_result      res;
        t_alarm_code        cls;
        t_chan_state        prev;
        logic [35:0]        cap;
        logic [LIMIT_W-1:0] persist;
        bit                 in_range;

        res      = '0;
        res.lim  = lim;
        in_range = int'(ch) < CHANNELS;
        prev     = in_range ? chan_state[ch] : STATE_RESET;

        // disabled: clear the class, pass thresholds through untouched
        if (!fl.enable) begin
            if (in_range)
                chan_state[ch].cls = CODE_OK;
            return res;
        end

        if (rated != '0) begin
            cap = (36'(rated) * 36'd13) / 36'd10;
            if (36'(lim.max_lim) > cap)
                lim.max_lim = cap[DATA_W-1:0];
        end
        if (lim.crit_max > lim.max_lim)
            lim.crit_max = lim.max_lim;
        if (lim.crit_min > lim.crit_max)
            lim.crit_min = lim.crit_max;
        if (lim.min_lim > lim.crit_min)
            lim.min_lim = lim.crit_min;
        res.lim = lim;

        // low checks override high checks
        cls = CODE_OK;
        if (value > lim.max_lim)
            cls = CODE_MAX;
        else if (value > lim.crit_max)
            cls = CODE_WARN_HIGH;
        if (value < lim.min_lim)
            cls = CODE_MIN;
        else if (value < lim.crit_min)
            cls = CODE_WARN_LOW;

        persist = fl.long_uptime ? PERSIST_LONG : PERSIST_BASE;
        if (fl.is_voltage)
            persist = persist + PERSIST_VOLT;

        if (cls == prev.cls) begin
            if (in_range)
                chan_state[ch].cnt = '0;
            res.code = cls;
        end else begin
            if (in_range && prev.cnt != CNT_MAX)
                chan_state[ch].cnt = prev.cnt + 1'b1;
            if (in_range && fl.commit_permit && prev.cnt > persist) begin
                chan_state[ch].cls = cls;
                res.code           = cls;
                res.changed        = 1'b1;
            end
        end

        res.severe  = (res.code == CODE_MAX) || (res.code == CODE_MIN);
        res.warning = (res.code == CODE_WARN_HIGH) || (res.code == CODE_WARN_LOW);
        return res;
    endfunction

    function automatic int field_bad(string name, logic [DATA_W-1:0] want,
                                     logic [DATA_W-1:0] got);
        if (want === got)
            return 0;
        $error("%s: expected %0d, actual %0d", name, want, got);
        return 1;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_alarm_result want;
        if (!i_rst_n) begin
            foreach (chan_state[k])
                chan_state[k] = STATE_RESET;
            alarm_q.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                if (alarm_q.size() == 0) begin
                    $error("result with no item outstanding: alarm_code %0d", i_alarm_code);
                    o_fail_count++;
                end else begin
                    want = alarm_q.pop_front();
                    o_fail_count += field_bad("alarm_code", want.code, i_alarm_code);
                    o_fail_count += field_bad("changed", want.changed, i_changed);
                    o_fail_count += field_bad("severe", want.severe, i_severe);
                    o_fail_count += field_bad("warning", want.warning, i_warning);
                    o_fail_count += field_bad("new_max", want.lim.max_lim,
                                              i_new_limits.max_lim);
                    o_fail_count += field_bad("new_crit_max", want.lim.crit_max,
                                              i_new_limits.crit_max);
                    o_fail_count += field_bad("new_crit_min", want.lim.crit_min,
                                              i_new_limits.crit_min);
                    o_fail_count += field_bad("new_min", want.lim.min_lim,
                                              i_new_limits.min_lim);
                end
            end
            if (i_in_valid && !i_in_stall)
                alarm_q.push_back(qualify_reading(i_channel, i_value, i_limits,
                                                  i_rated_value, i_flags));
        end
        o_pending = alarm_q.size();
    end

endmodule

### sim/tb_top.sv
// Testbench top for threshold_alarm_qualifier_top: drives directed and random items,
// idles both channels and gives the verdict. Depends on taq_pkg and taq_alarm_checker.
module tb_top import taq_pkg::*; ();

    // one input item as presented on the ports
    typedef struct packed {
        logic [CH_W-1:0]   channel;
        logic [DATA_W-1:0] value;
        t_limits           lim;
        logic [DATA_W-1:0] rated;
        t_flags            flags;
    } t_reading;

    localparam int RANDOM_ITEMS = 650;
    localparam int SAT_RUN      = 262;   // enough to pin a mismatch count at its ceiling
    localparam int QUIET_LIMIT  = 2000;  // cycles with no handshake before giving up
    localparam int DRAIN_CYCLES = 20;    // margin after the last expected result; leave room for strays

    // plain ascending ladder used by the directed part
    localparam t_limits LIM_LADDER = '{max_lim: 32'd400, crit_max: 32'd300,
                                       crit_min: 32'd200, min_lim: 32'd100};
    localparam t_limits LIM_INVERTED = '{max_lim: 32'd10, crit_max: 32'd20,
                                         crit_min: 32'd30, min_lim: 32'd40};
    localparam t_flags FL_PLAIN = '{enable: 1'b1, is_voltage: 1'b0,
                                    long_uptime: 1'b0, commit_permit: 1'b1};
    localparam t_flags FL_HOLD  = '{enable: 1'b1, is_voltage: 1'b0,
                                    long_uptime: 1'b0, commit_permit: 1'b0};
    // other flags set on purpose: a disabled channel must ignore them
    localparam t_flags FL_OFF   = '{enable: 1'b0, is_voltage: 1'b1,
                                    long_uptime: 1'b1, commit_permit: 1'b1};

    logic     clk;
    logic     rst_n     = 1'b0;
    t_reading cur       = '0;
    logic     in_valid  = 1'b0;
    logic     in_stall;
    logic     res_valid;
    logic     res_stall = 1'b0;

    logic [2:0]        res_code;
    logic              res_changed;
    logic              res_severe;
    logic              res_warning;
    logic [DATA_W-1:0] res_max;
    logic [DATA_W-1:0] res_cmax;
    logic [DATA_W-1:0] res_cmin;
    logic [DATA_W-1:0] res_min;

    int idle_pct  = 29;   // sender gap chance per cycle, percent
    int stall_pct = 74;   // receiver stall chance per cycle, percent
    int sent      = 0;
    int fail_count;
    int pending;

    threshold_alarm_qualifier_top i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_valid          (in_valid),
        .o_stall          (in_stall),
        .i_channel        (cur.channel),
        .i_value          (cur.value),
        .i_max_limit      (cur.lim.max_lim),
        .i_crit_max_limit (cur.lim.crit_max),
        .i_crit_min_limit (cur.lim.crit_min),
        .i_min_limit      (cur.lim.min_lim),
        .i_rated_value    (cur.rated),
        .i_enable         (cur.flags.enable),
        .i_is_voltage     (cur.flags.is_voltage),
        .i_long_uptime    (cur.flags.long_uptime),
        .i_commit_permit  (cur.flags.commit_permit),
        .o_valid          (res_valid),
        .i_stall          (res_stall),
        .o_alarm_code     (res_code),
        .o_changed        (res_changed),
        .o_severe         (res_severe),
        .o_warning        (res_warning),
        .o_new_max        (res_max),
        .o_new_crit_max   (res_cmax),
        .o_new_crit_min   (res_cmin),
        .o_new_min        (res_min)
    );

    taq_alarm_checker i_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_channel     (cur.channel),
        .i_value       (cur.value),
        .i_limits      (cur.lim),
        .i_rated_value (cur.rated),
        .i_flags       (cur.flags),
        .i_res_valid   (res_valid),
        .i_res_stall   (res_stall),
        .i_alarm_code  (res_code),
        .i_changed     (res_changed),
        .i_severe      (res_severe),
        .i_warning     (res_warning),
        .i_new_limits  ({res_max, res_cmax, res_cmin, res_min}),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver side: stall decided fresh every cycle, changes on the falling edge
    always @(negedge clk) begin
        res_stall <= ($urandom_range(99) < stall_pct);
    end

    // watchdog: any accepted item or result restarts the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (res_valid && !res_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("threshold_alarm_qualifier_top regression: fail");
        $finish;
    end

    function automatic t_reading make_reading(logic [CH_W-1:0] ch, logic [DATA_W-1:0] value,
                                              t_limits lim, logic [DATA_W-1:0] rated,
                                              t_flags fl);
        return '{channel: ch, value: value, lim: lim, rated: rated, flags: fl};
    endfunction

    // ascending thresholds (crit_min may equal crit_max), from base 1 or a random base up to 32'hF000_0000;
    // min is never 0 and max is never all ones, so every class can be reached
    function automatic t_limits ordered_limits();
        t_limits           l;
        logic [DATA_W-1:0] base;
        base       = ($urandom_range(1) == 1) ? $urandom_range(32'hF000_0000, 1) : 32'd1;
        l.min_lim  = base + $urandom_range(1 << 20, 0);
        l.crit_min = l.min_lim + $urandom_range(4096, 1);
        l.crit_max = l.crit_min + $urandom_range(1 << 20, 0);
        l.max_lim  = l.crit_max + $urandom_range(4096, 1);
        return l;
    endfunction

    // reading that lands in the given class for an ordered set of limits;
    // region edges are picked half of the time
    function automatic logic [DATA_W-1:0] value_in_class(t_limits l, t_alarm_code c);
        logic [DATA_W-1:0] lo;
        logic [DATA_W-1:0] hi;
        case (c)
            CODE_MAX: begin
                lo = l.max_lim + 1'b1;
                hi = '1;
            end
            CODE_WARN_HIGH: begin
                lo = l.crit_max + 1'b1;
                hi = l.max_lim;
            end
            CODE_WARN_LOW: begin
                lo = l.min_lim;
                hi = l.crit_min - 1'b1;
            end
            CODE_MIN: begin
                lo = '0;
                hi = l.min_lim - 1'b1;
            end
            default: begin
                lo = l.crit_min;
                hi = l.crit_max;
            end
        endcase
        case ($urandom_range(3))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(hi, lo);
        endcase
    endfunction

    // anything goes: random thresholds get reordered and capped by the block on an enabled channel
    function automatic t_reading noise_reading();
        t_reading it;
        it.channel = CH_W'($urandom);
        it.value   = $urandom;
        it.lim     = {$urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(2))
            0:       it.rated = '0;
            1:       it.rated = $urandom_range(1000, 1);
            default: it.rated = $urandom;
        endcase
        it.flags        = 4'($urandom);
        it.flags.enable = ($urandom_range(9) != 0);
        return it;
    endfunction

    // present one item and hold it until accepted; entered and left just after
    // a falling edge, so valid is written once per step
    task automatic send_item(input t_reading it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        cur      <= it;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    // same channel, same class, fixed uptime/voltage flags: the count can climb past
    // the limit, and the class commits once the permit is there
    task automatic persistence_run();
        t_reading    it;
        t_alarm_code target;
        int          len;
        int          k;
        it.channel = CH_W'($urandom);
        it.lim     = ordered_limits();
        it.rated   = ($urandom_range(1) == 1) ? '0 : it.lim.max_lim + $urandom_range(1000, 0);
        it.flags   = '{enable: 1'b1, is_voltage: 1'($urandom_range(1)),
                       long_uptime: 1'($urandom_range(1)), commit_permit: 1'b0};
        target     = t_alarm_code'($urandom_range(4, 0));
        len        = $urandom_range(18, 3);
        for (k = 0; k < len; k++) begin
            it.flags.commit_permit = ($urandom_range(99) < 70);
            // an odd stray reading breaks the run now and then
            it.value = ($urandom_range(99) < 8) ? $urandom : value_in_class(it.lim, target);
            send_item(it);
        end
    endtask

    // drive one channel's count to its ceiling with the permit withheld, then commit
    // twice in a row while the count stays pinned, then settle
    task automatic saturate_channel();
        t_reading it;
        int       k;
        it.channel = CH_W'($urandom);
        it.lim     = ordered_limits();
        it.rated   = '0;
        it.value   = value_in_class(it.lim, CODE_OK);
        it.flags   = FL_OFF;
        send_item(it);
        it.flags = '{enable: 1'b1, is_voltage: 1'b1, long_uptime: 1'b1, commit_permit: 1'b0};
        it.value = value_in_class(it.lim, CODE_MAX);
        for (k = 0; k < SAT_RUN; k++)
            send_item(it);
        it.flags.commit_permit = 1'b1;
        send_item(it);
        it.value = value_in_class(it.lim, CODE_MIN);
        send_item(it);
        send_item(it);
    endtask

    initial begin : stimulus
        logic [DATA_W-1:0] ladder_vals [6];
        int                rnd_base;
        int                progress;
        int                pick;
        bit                sat_done;
        t_reading          it;

        ladder_vals = '{32'd99, 32'd100, 32'd200, 32'd300, 32'd301, 32'd401};
        sat_done    = 1'b0;

        // synchronous reset, released just after a falling edge
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // all-zero and all-ones fields
        send_item(make_reading(6'd0, '0, '0, '0, FL_PLAIN));
        send_item(make_reading(6'd63, '1, '1, '1, FL_PLAIN));
        // reading above every limit on a fresh channel
        send_item(make_reading(6'd2, '1, '0, '0, FL_PLAIN));
        // inverted thresholds are forced back into order
        send_item(make_reading(6'd3, 32'd15, LIM_INVERTED, '0, FL_PLAIN));
        // rated value caps max: smallest caps, 1 -> 1 and 10 -> 13
        send_item(make_reading(6'd4, 32'd1, '1, 32'd1, FL_PLAIN));
        send_item(make_reading(6'd4, 32'd13, '1, 32'd10, FL_PLAIN));
        // cap just past 32 bits leaves max alone, one step lower it bites
        send_item(make_reading(6'd5, '1, '1, 32'hC4EC_4EC5, FL_PLAIN));
        send_item(make_reading(6'd5, '1, '1, 32'hC4EC_4EC4, FL_PLAIN));
        // disabled channel: thresholds come back uncorrected, class cleared
        send_item(make_reading(6'd3, 32'd15, LIM_INVERTED, 32'd1, FL_OFF));
        // each class edge of the ladder, both sides
        foreach (ladder_vals[k])
            send_item(make_reading(6'd6, ladder_vals[k], LIM_LADDER, '0, FL_PLAIN));
        // base limit 3: the fifth consecutive max reading commits
        repeat (5)
            send_item(make_reading(6'd1, 32'd500, LIM_LADDER, '0, FL_PLAIN));
        // stored class now matches: reported, count cleared
        send_item(make_reading(6'd1, 32'd500, LIM_LADDER, '0, FL_PLAIN));
        // mismatches without and with permit, below the limit
        send_item(make_reading(6'd1, 32'd350, LIM_LADDER, '0, FL_HOLD));
        send_item(make_reading(6'd1, 32'd50, LIM_LADDER, '0, FL_PLAIN));
        // disable keeps the count, clears the class
        send_item(make_reading(6'd1, 32'd250, LIM_LADDER, '0, FL_OFF));
        send_item(make_reading(6'd1, 32'd50, LIM_LADDER, '0, FL_PLAIN));

        // ---- random part, in three idling phases ----
        rnd_base = sent;
        while (sent - rnd_base < RANDOM_ITEMS) begin
            progress = sent - rnd_base;
            if (progress < RANDOM_ITEMS / 3) begin
                idle_pct  = 29;
                stall_pct = 74;
            end else if (progress < 2 * RANDOM_ITEMS / 3) begin
                idle_pct  = 74;
                stall_pct = 29;
            end else begin
                idle_pct  = 0;
                stall_pct = 0;
            end

            if (!sat_done && progress >= RANDOM_ITEMS / 2) begin
                saturate_channel();
                sat_done = 1'b1;
            end else begin
                pick = $urandom_range(99);
                if (pick < 30) begin
                    send_item(noise_reading());
                end else if (pick < 90) begin
                    persistence_run();
                end else begin
                    it              = noise_reading();
                    it.flags.enable = 1'b0;
                    send_item(it);
                end
            end
        end
        in_valid <= 1'b0;

        // drain: every expected result in, then a margin for anything extra
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("threshold_alarm_qualifier_top regression: pass");
        else
            $display("threshold_alarm_qualifier_top regression: fail");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/taq_pkg.sv
hw/rtl/taq_classify.sv
hw/rtl/taq_state.sv
hw/rtl/threshold_alarm_qualifier_top.sv
hw/rtl/taq_checker.sv
sim/taq_alarm_checker.sv
sim/tb_top.sv
